// ===== rtl/pee_pkg.sv =====
package pee_pkg;

	localparam int CHAR_W   = 8;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;

	typedef logic [DATA_W-1:0] word_t;
	typedef logic [CHAR_W-1:0] char_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_DIVZERO   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_NINE  = 8'h39;
	localparam char_t CH_PLUS  = 8'h2B;
	localparam char_t CH_MINUS = 8'h2D;
	localparam char_t CH_STAR  = 8'h2A;
	localparam char_t CH_SLASH = 8'h2F;
	localparam char_t CH_CLOSE = 8'h29;

	typedef struct packed {
		logic  start;
		word_t dividend;
		word_t divisor;
	} div_req_t;

	typedef struct packed {
		logic  done;
		word_t quotient;
	} div_rsp_t;

	function automatic status_t note_status(status_t cur, status_t code);
		note_status = (cur == ST_OK) ? code : cur;
	endfunction

endpackage

// ===== rtl/pee_chan_if.sv =====
interface pee_char_if;
	logic                        valid;
	logic                        ready;
	logic [pee_pkg::CHAR_W-1:0]  char_code;

	modport source (output valid, output char_code, input ready);
	modport sink   (input valid, input char_code, output ready);
endinterface

interface pee_result_if;
	logic                         valid;
	logic                         ready;
	logic signed [pee_pkg::DATA_W-1:0]   result_value;
	logic [pee_pkg::STATUS_W-1:0] status_code;

	modport source (output valid, output result_value, output status_code, input ready);
	modport sink   (input valid, input result_value, input status_code, output ready);
endinterface

// ===== rtl/pee_div.sv =====
module pee_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pee_pkg::div_req_t req,
	output pee_pkg::div_rsp_t rsp
);

	localparam int DW = pee_pkg::DATA_W;
	localparam int NW = $clog2(DW);

	logic          busy_q;
	logic          done_q;
	logic          neg_q;
	logic [NW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [DW-1:0] dvs_q;

	logic [DW:0]   shifted;
	logic [DW:0]   diff;
	logic [DW-1:0] abs_dividend;
	logic [DW-1:0] abs_divisor;

	assign abs_dividend = req.dividend[DW-1] ? (~req.dividend + 1'b1) : req.dividend;
	assign abs_divisor  = req.divisor[DW-1]  ? (~req.divisor + 1'b1)  : req.divisor;
	assign shifted      = {rem_q, quo_q[DW-1]};
	assign diff         = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= NW'(DW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= abs_dividend;
			dvs_q <= abs_divisor;
			neg_q <= req.dividend[DW-1] ^ req.divisor[DW-1];
		end else if (busy_q) begin
			if (!diff[DW]) begin
				rem_q <= diff[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");

	a_last_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q == '0 && !req.start) |=> (rsp.done && !busy_q))
		else $error("divider missed completion");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done)
		else $error("divider done held");

endmodule

// ===== rtl/postfix_expression_evaluator.sv =====
// Digit or ignored character: taken in idle. '+', '-', '*': two stack reads, execute,
// write back. '/': the same, with the 32-step restoring divider after execute, which a
// zero divisor skips. ')': top of stack and status are registered into the output once
// it is free; no characters are taken meanwhile. Only one character is in work at once.
// Reset clears stack count, status, sequencer and output valid; stack memory is not cleared.
module postfix_expression_evaluator #(
	parameter int STACK_DEPTH = 128
) (
	input logic          clk,
	input logic          arst_n,
	pee_char_if.sink     chars,
	pee_result_if.source results
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int DW = pee_pkg::DATA_W;
	localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RDA  = 7'b0000010,
		S_RDB  = 7'b0000100,
		S_EXEC = 7'b0001000,
		S_DIV  = 7'b0010000,
		S_PUSH = 7'b0100000,
		S_END  = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	pee_pkg::status_t  sticky_q;
	pee_pkg::op_t      op_q;
	logic              a_ok_q;
	logic              b_ok_q;
	pee_pkg::word_t    a_q;
	pee_pkg::word_t    b_q;
	pee_pkg::word_t    r_q;
	logic              out_valid_q;
	pee_pkg::word_t    out_value_q;
	pee_pkg::status_t  out_status_q;

	pee_pkg::word_t    mem [STACK_DEPTH];
	pee_pkg::word_t    rdata_q;
	logic [AW-1:0]     raddr;
	logic [AW-1:0]     waddr;
	pee_pkg::word_t    wdata;
	logic              mem_we;

	logic              accept;
	logic              is_digit;
	logic              is_op;
	logic              is_close;
	logic              out_load;
	logic [CW-1:0]     cnt_m1;
	logic [CW-1:0]     cnt_m2;
	pee_pkg::op_t      op_dec;
	pee_pkg::div_req_t div_req;
	pee_pkg::div_rsp_t div_rsp;

	assign chars.ready = (state_q == S_IDLE);
	assign accept      = chars.valid && chars.ready;

	assign is_digit = (chars.char_code >= pee_pkg::CH_ZERO) &&
	                  (chars.char_code <= pee_pkg::CH_NINE);
	assign is_op    = (chars.char_code == pee_pkg::CH_PLUS)  ||
	                  (chars.char_code == pee_pkg::CH_MINUS) ||
	                  (chars.char_code == pee_pkg::CH_STAR)  ||
	                  (chars.char_code == pee_pkg::CH_SLASH);
	assign is_close = (chars.char_code == pee_pkg::CH_CLOSE);

	always_comb begin
		case (chars.char_code)
			pee_pkg::CH_PLUS:  op_dec = pee_pkg::OP_ADD;
			pee_pkg::CH_MINUS: op_dec = pee_pkg::OP_SUB;
			pee_pkg::CH_STAR:  op_dec = pee_pkg::OP_MUL;
			default:           op_dec = pee_pkg::OP_DIV;
		endcase
	end

	assign cnt_m1 = count_q - CW'(1);
	assign cnt_m2 = count_q - CW'(2);
	assign raddr  = (state_q == S_RDA) ? cnt_m2[AW-1:0] : cnt_m1[AW-1:0];
	assign waddr  = count_q[AW-1:0];
	assign wdata  = (state_q == S_PUSH) ? r_q :
	                {{(DW - 4){1'b0}}, chars.char_code[3:0]};
	assign mem_we = (state_q == S_PUSH) ||
	                (accept && is_digit && count_q != FULL);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign out_load = (state_q == S_END) && (!out_valid_q || results.ready);

	assign div_req.start    = (state_q == S_EXEC) && (op_q == pee_pkg::OP_DIV) && (a_q != '0);
	assign div_req.dividend = b_q;
	assign div_req.divisor  = a_q;

	pee_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			sticky_q    <= pee_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && is_digit) begin
						if (count_q == FULL) begin
							sticky_q <= pee_pkg::note_status(sticky_q, pee_pkg::ST_OVERFLOW);
						end else begin
							count_q <= count_q + CW'(1);
						end
					end else if (accept && is_op) begin
						if (count_q < CW'(2)) begin
							sticky_q <= pee_pkg::note_status(sticky_q, pee_pkg::ST_UNDERFLOW);
						end
						state_q <= S_RDA;
					end else if (accept && is_close) begin
						if (count_q == '0) begin
							sticky_q <= pee_pkg::note_status(sticky_q, pee_pkg::ST_UNDERFLOW);
						end
						state_q <= S_END;
					end
				end
				S_RDA: state_q <= S_RDB;
				S_RDB: begin
					count_q <= b_ok_q ? cnt_m2 : '0;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (div_req.start) begin
						state_q <= S_DIV;
					end else begin
						if (op_q == pee_pkg::OP_DIV) begin
							sticky_q <= pee_pkg::note_status(sticky_q, pee_pkg::ST_DIVZERO);
						end
						state_q <= S_PUSH;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					count_q <= count_q + CW'(1);
					state_q <= S_IDLE;
				end
				S_END: begin
					if (out_load) begin
						count_q  <= '0;
						sticky_q <= pee_pkg::ST_OK;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_dec;
			a_ok_q <= (count_q != '0);
			b_ok_q <= (count_q >= CW'(2));
		end
		if (state_q == S_RDA) begin
			a_q <= a_ok_q ? rdata_q : '0;
		end
		if (state_q == S_RDB) begin
			b_q <= b_ok_q ? rdata_q : '0;
		end
		if (state_q == S_EXEC) begin
			case (op_q)
				pee_pkg::OP_ADD: r_q <= b_q + a_q;
				pee_pkg::OP_SUB: r_q <= b_q - a_q;
				pee_pkg::OP_MUL: r_q <= b_q * a_q;
				default:         r_q <= '0;
			endcase
		end
		if (state_q == S_DIV && div_rsp.done) begin
			r_q <= div_rsp.quotient;
		end
		if (out_load) begin
			out_value_q  <= a_ok_q ? rdata_q : '0;
			out_status_q <= sticky_q;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.result_value = out_value_q;
	assign results.status_code  = out_status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("stack count beyond depth");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUSH) |-> (count_q != FULL))
		else $error("operator result pushed onto full stack");

	a_sticky_first: assert property (@(posedge clk) disable iff (!arst_n)
		(sticky_q != pee_pkg::ST_OK) |=>
		(sticky_q == pee_pkg::ST_OK || sticky_q == $past(sticky_q)))
		else $error("sticky status overwritten");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (count_q == '0 && sticky_q == pee_pkg::ST_OK && results.valid))
		else $error("end marker did not clear expression state");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import pee_pkg::*;

	localparam int    STACK_DEPTH   = 128;
	localparam int    RANDOM_ITEMS  = 1450;
	localparam int    CALM_FROM     = 700;
	localparam int    CALM_TO       = 1000;
	localparam int    PRESSURE_AT   = 400;
	localparam int    HOLD_CYCLES   = 600;
	localparam int    DRAIN_CYCLES  = 64;
	localparam int    CYCLE_LIMIT   = 400_000;
	localparam int    REPORT_LIMIT  = 10;
	localparam word_t MOST_NEGATIVE = {1'b1, {(DATA_W-1){1'b0}}};
	localparam word_t MINUS_ONE     = {DATA_W{1'b1}};

	typedef struct packed {
		word_t   value;
		status_t status;
	} rpn_result_t;

	class postfix_tracker;
		word_t       stack_mem [STACK_DEPTH];
		int          depth_used;
		status_t     sticky;
		rpn_result_t pending [$];
		int          mismatches;
		int          checked;
		int          status_seen [4];

		function new();
			depth_used = 0;
			sticky     = ST_OK;
			mismatches = 0;
			checked    = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function void record_error(status_t code);
			if (sticky == ST_OK) sticky = code;
		endfunction

		function void push_word(word_t v);
			if (depth_used >= STACK_DEPTH) begin
				record_error(ST_OVERFLOW);
			end else begin
				stack_mem[depth_used] = v;
				depth_used++;
			end
		endfunction

		function word_t pop_word();
			if (depth_used == 0) begin
				record_error(ST_UNDERFLOW);
				return '0;
			end
			depth_used--;
			return stack_mem[depth_used];
		endfunction

		function void take_char(char_t c);
			word_t       a;
			word_t       b;
			word_t       r;
			rpn_result_t res;
			if (c >= CH_ZERO && c <= CH_NINE) begin
				push_word(word_t'(c - CH_ZERO));
			end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
				a = pop_word();
				b = pop_word();
				case (c)
					CH_PLUS:  r = b + a;
					CH_MINUS: r = b - a;
					CH_STAR:  r = b * a;
					default: begin
						if (a == '0) begin
							record_error(ST_DIVZERO);
							r = '0;
						end else if (b == MOST_NEGATIVE && a == MINUS_ONE) begin
							r = MOST_NEGATIVE;
						end else begin
							r = word_t'($signed(b) / $signed(a));
						end
					end
				endcase
				push_word(r);
			end else if (c == CH_CLOSE) begin
				res.value  = pop_word();
				res.status = sticky;
				pending.push_back(res);
				depth_used = 0;
				sticky     = ST_OK;
			end
		endfunction

		function void check_result(word_t v, logic [STATUS_W-1:0] s);
			rpn_result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result: value %0d status %0d", $signed(v), s);
				return;
			end
			want = pending.pop_front();
			checked++;
			status_seen[want.status]++;
			if (v !== want.value || s !== want.status) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display({"result %0d mismatch: expected value %0d status %0d, ",
						"got value %0d status %0d"},
						checked, $signed(want.value), want.status, $signed(v), s);
			end
		endfunction
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	pee_char_if   chars_if ();
	pee_result_if results_if ();

	postfix_expression_evaluator #(
		.STACK_DEPTH(STACK_DEPTH)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.results(results_if)
	);

	postfix_tracker tracker = new();
	char_t          char_plan [$];
	int             sent_count  = 0;
	int             cycle_count = 0;
	bit             no_idle     = 1'b0;
	bit             hold_off    = 1'b0;

	always #2 clk = ~clk;

	function automatic bit want_idle();
		return !no_idle && ($urandom_range(0, 99) < 10);
	endfunction

	function automatic char_t random_digit(int lo = 0);
		return char_t'(CH_ZERO + $urandom_range(lo, 9));
	endfunction

	function automatic char_t random_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) return CH_PLUS;
		if (r < 50) return CH_MINUS;
		if (r < 80) return CH_STAR;
		return CH_SLASH;
	endfunction

	function automatic char_t random_ignored();
		char_t c;
		do begin
			c = char_t'($urandom_range(0, 255));
		end while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS ||
			c == CH_STAR || c == CH_SLASH || c == CH_CLOSE);
		return c;
	endfunction

	task automatic plan_text(string s);
		for (int i = 0; i < s.len(); i++) char_plan.push_back(char_t'(s[i]));
	endtask

	task automatic plan_expression(int operands, bit sprinkle);
		int depth;
		int left;
		depth = 0;
		left  = operands;
		while (left > 0 || depth > 1) begin
			if (left > 0 && (depth < 2 || $urandom_range(0, 2) != 0)) begin
				char_plan.push_back(random_digit());
				depth++;
				left--;
			end else begin
				char_plan.push_back(random_op());
				depth--;
			end
			if (sprinkle && $urandom_range(0, 15) == 0) char_plan.push_back(random_ignored());
		end
		char_plan.push_back(CH_CLOSE);
	endtask

	task automatic plan_product_chain();
		char_plan.push_back(random_digit(1));
		repeat ($urandom_range(3, 14)) begin
			char_plan.push_back(random_digit(1));
			char_plan.push_back(($urandom_range(0, 4) == 0) ? CH_MINUS : CH_STAR);
		end
		if ($urandom_range(0, 1)) begin
			char_plan.push_back(random_digit(1));
			char_plan.push_back(CH_SLASH);
		end
		char_plan.push_back(CH_CLOSE);
	endtask

	task automatic plan_broken();
		int r;
		repeat ($urandom_range(1, 12)) begin
			r = $urandom_range(0, 9);
			if (r < 4)      char_plan.push_back(random_digit());
			else if (r < 7) char_plan.push_back(random_op());
			else if (r < 9) char_plan.push_back(CH_CLOSE);
			else            char_plan.push_back(random_ignored());
		end
	endtask

	task automatic plan_flood();
		repeat (STACK_DEPTH + $urandom_range(1, 3)) char_plan.push_back(random_digit());
		repeat ($urandom_range(0, 3)) char_plan.push_back(random_op());
		char_plan.push_back(CH_CLOSE);
	endtask

	task automatic plan_stimulus();
		int r;
		int target;
		char_plan.push_back(8'h00);
		char_plan.push_back(8'hFF);
		plan_text(")");
		plan_text("5)");
		plan_text("93+4-2*)");
		plan_text("83/)");
		plan_text("38-2/)");
		plan_text("90/)");
		plan_text("+90/)");
		plan_text("29 1)");
		plan_text("88*8*8*8*8*8*8*8*8*2*01-/)");
		plan_flood();
		target = RANDOM_ITEMS;
		while (char_plan.size() < target) begin
			r = $urandom_range(0, 99);
			if (r < 60)      plan_expression($urandom_range(1, 8), 1'b1);
			else if (r < 73) plan_product_chain();
			else if (r < 85) plan_broken();
			else if (r < 95)
				repeat ($urandom_range(1, 6))
					char_plan.push_back(char_t'($urandom_range(0, 255)));
			else if (r < 98) plan_text("88*8*8*8*8*8*8*8*8*2*01-/)");
			else if ($urandom_range(0, 2) == 0) plan_flood();
			else             plan_expression($urandom_range(20, 40), 1'b0);
		end
	endtask

	task automatic send_char(char_t c);
		while (want_idle()) begin
			chars_if.valid <= 1'b0;
			@(posedge clk);
		end
		chars_if.valid     <= 1'b1;
		chars_if.char_code <= c;
		@(posedge clk);
		while (!chars_if.ready) @(posedge clk);
		tracker.take_char(c);
		sent_count++;
	endtask

	// receive results and check each transaction
	initial begin
		results_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (results_if.valid === 1'b1 && results_if.ready === 1'b1)
				tracker.check_result(results_if.result_value, results_if.status_code);
			results_if.ready <= !hold_off && !want_idle();
		end
	end

	// hold the result channel off so the input stalls
	initial begin
		wait (sent_count >= PRESSURE_AT);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** postfix_expression_evaluator: FAILED **");
		$finish;
	end

	initial begin
		chars_if.valid     <= 1'b0;
		chars_if.char_code <= '0;
		plan_stimulus();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (char_plan[i]) begin
			no_idle <= (i >= CALM_FROM && i < CALM_TO);
			send_char(char_plan[i]);
		end
		chars_if.valid <= 1'b0;
		no_idle        <= 1'b0;
		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d characters, checked %0d expression results in %0d cycles",
			sent_count, tracker.checked, cycle_count);
		$display("status mix: %0d ok, %0d overflow, %0d underflow, %0d divide by zero",
			tracker.status_seen[ST_OK], tracker.status_seen[ST_OVERFLOW],
			tracker.status_seen[ST_UNDERFLOW], tracker.status_seen[ST_DIVZERO]);
		if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
			$display("** postfix_expression_evaluator: PASSED **");
		end else begin
			$display("** postfix_expression_evaluator: FAILED **");
		end
		$finish;
	end

endmodule
